/* design/sprite_line_compositor_defines.svh */
// Assertion macros shared by the compositor RTL.
`ifndef SPRITE_LINE_COMPOSITOR_DEFINES_SVH
`define SPRITE_LINE_COMPOSITOR_DEFINES_SVH

// same-cycle implication
`define SLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/slc_pkg.sv */
// Package: shared types and constants of the sprite line compositor.
`default_nettype none
package slc_pkg;

    localparam int LINE_WIDTH    = 320;
    localparam int MAP_DEPTH     = 560;
    localparam int SPRITE_OFFSET = 24;
    localparam int LX_W          = 9;
    localparam int MA_W          = 10;
    localparam int K_W           = 6;
    localparam int Q_DEPTH       = 2;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_ROW  = 2'd1;
    localparam logic [1:0] REQ_EOL  = 2'd2;

    localparam logic [1:0] CFG_BG  = 2'd0;
    localparam logic [1:0] CFG_MC0 = 2'd1;
    localparam logic [1:0] CFG_MC1 = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_ROW  = 2'd1,
        KIND_EOL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  pixel_x;
        logic [3:0]  pixel_color;
        logic [2:0]  sprite_index;
        logic [8:0]  sprite_x;
        logic [23:0] row_bits;
        logic        multicolor;
        logic        expand_x;
        logic        behind_background;
        logic [3:0]  sprite_color;
    } t_item;

    typedef struct packed {
        logic [3:0] background_color;
        logic [3:0] multicolor_zero;
        logic [3:0] multicolor_one;
    } t_cfg;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage
`default_nettype wire

/* design/slc_queue.sv */
// Short FIFO between the front classifier and the back executor.
`default_nettype none
module slc_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  slc_pkg::t_item   i_item,
    output logic             o_full,
    input  wire              i_pop,
    output slc_pkg::t_qhead  o_head
);
    slc_pkg::t_item r_mem [slc_pkg::Q_DEPTH];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_full      = (r_cnt == 2'(slc_pkg::Q_DEPTH));
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];
endmodule
`default_nettype wire

/* design/slc_front.sv */
// Front: accepts input words, drops unused codes and loads past the line, classifies the rest.
`default_nettype none
module slc_front (
    input  wire             i_valid,
    output logic            o_ready,
    input  wire [1:0]       i_req_type,
    input  wire [8:0]       i_pixel_x,
    input  wire [3:0]       i_pixel_color,
    input  wire [2:0]       i_sprite_index,
    input  wire [8:0]       i_sprite_x,
    input  wire [23:0]      i_row_bits,
    input  wire             i_multicolor,
    input  wire             i_expand_x,
    input  wire             i_behind_background,
    input  wire [3:0]       i_sprite_color,
    input  wire             i_q_full,
    output logic            o_push,
    output slc_pkg::t_item  o_item
);
    logic keep;

    always_comb begin
        o_item.pixel_x           = i_pixel_x;
        o_item.pixel_color       = i_pixel_color;
        o_item.sprite_index      = i_sprite_index;
        o_item.sprite_x          = i_sprite_x;
        o_item.row_bits          = i_row_bits;
        o_item.multicolor        = i_multicolor;
        o_item.expand_x          = i_expand_x;
        o_item.behind_background = i_behind_background;
        o_item.sprite_color      = i_sprite_color;
        case (i_req_type)
            slc_pkg::REQ_LOAD: begin
                o_item.kind = slc_pkg::KIND_LOAD;
                keep = ({1'b0, i_pixel_x} < 10'(slc_pkg::LINE_WIDTH));
            end
            slc_pkg::REQ_ROW: begin
                o_item.kind = slc_pkg::KIND_ROW;
                keep = 1'b1;
            end
            slc_pkg::REQ_EOL: begin
                o_item.kind = slc_pkg::KIND_EOL;
                keep = 1'b1;
            end
            default: begin
                o_item.kind = slc_pkg::KIND_LOAD;
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;
endmodule
`default_nettype wire

/* design/slc_back.sv */
// Back: line store, collision map, pixel sequencer and result register.
`default_nettype none
module slc_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  slc_pkg::t_cfg    i_cfg,
    input  slc_pkg::t_qhead  i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output logic             o_result_kind,
    output logic [8:0]       o_out_x,
    output logic [3:0]       o_out_color,
    output logic             o_last,
    output logic [7:0]       o_collided_mask,
    output logic [7:0]       o_collision_latch,
    output logic             o_collision_irq
);
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_WR    = 6'b001000,
        S_FLUSH = 6'b010000,
        S_EOL   = 6'b100000
    } t_state;

    logic [3:0] r_line [slc_pkg::LINE_WIDTH];
    logic [7:0] r_map  [slc_pkg::MAP_DEPTH];
    logic [3:0] r_line_q;
    logic [7:0] r_map_q;

    t_state r_st, n_st;
    logic [slc_pkg::MA_W-1:0] r_clr, n_clr;
    logic [slc_pkg::K_W-1:0]  r_k, n_k;
    slc_pkg::t_item r_row;
    logic [7:0] r_coll, n_coll, r_latch, n_latch;
    logic       r_pv, n_pv;
    logic [8:0] r_px, n_px;
    logic [3:0] r_pc, n_pc;
    logic       n_valid, n_kind, n_last, n_irq;
    logic [8:0] n_x;
    logic [3:0] n_color;
    logic [7:0] n_mask, n_olatch;

    logic [slc_pkg::K_W-1:0] total, unit;
    logic [4:0]  bidx, pidx;
    logic [1:0]  pair;
    logic        opaque;
    logic [3:0]  pcolor;
    logic signed [10:0] pos;
    logic        on_line, mi_ok, out_free, emit;
    logic [slc_pkg::MA_W-1:0] mi;
    logic [slc_pkg::LX_W-1:0] lx;
    logic        line_we, map_we, rd_en;
    logic [slc_pkg::LX_W-1:0] line_wa;
    logic [3:0]  line_wd;
    logic [slc_pkg::MA_W-1:0] map_wa;
    logic [7:0]  map_wd, bitm;

    always_comb begin
        total  = r_row.expand_x ? 6'd48 : 6'd24;
        unit   = r_k >> ({1'b0, r_row.multicolor} + {1'b0, r_row.expand_x});
        bidx   = 5'd23 - unit[4:0];
        pidx   = 5'd23 - {unit[3:0], 1'b0};
        pair   = {r_row.row_bits[pidx], r_row.row_bits[5'(pidx - 5'd1)]};
        if (!r_row.multicolor) begin
            opaque = r_row.row_bits[bidx];
            pcolor = r_row.sprite_color;
        end else begin
            opaque = (pair != 2'd0);
            case (pair)
                2'd1:    pcolor = i_cfg.multicolor_zero;
                2'd2:    pcolor = r_row.sprite_color;
                default: pcolor = i_cfg.multicolor_one;
            endcase
        end
        pos     = $signed({2'b00, r_row.sprite_x}) + $signed({5'd0, r_k})
                  - 11'sd24;
        on_line = !pos[10] && (pos[9:0] < 10'(slc_pkg::LINE_WIDTH));
        lx      = pos[slc_pkg::LX_W-1:0];
        mi      = {1'b0, r_row.sprite_x} + {4'd0, r_k};
        mi_ok   = (mi < 10'(slc_pkg::MAP_DEPTH));
        bitm    = 8'd1 << r_row.sprite_index;
        out_free = !o_valid || i_ready;
    end

    always_comb begin
        n_st = r_st;  n_clr = r_clr;  n_k = r_k;
        n_coll = r_coll;  n_latch = r_latch;
        n_pv = r_pv;  n_px = r_px;  n_pc = r_pc;
        n_valid = o_valid && !i_ready;
        n_kind = o_result_kind;  n_x = o_out_x;  n_color = o_out_color;
        n_last = o_last;  n_mask = o_collided_mask;
        n_olatch = o_collision_latch;  n_irq = o_collision_irq;
        o_pop = 1'b0;  rd_en = 1'b0;  emit = 1'b0;
        line_we = 1'b0;  line_wa = lx;  line_wd = pcolor;
        map_we = 1'b0;  map_wa = mi;  map_wd = r_map_q | bitm;
        case (r_st)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                map_wd = 8'd0;
                n_clr  = r_clr + 10'd1;
                if (r_clr == 10'(slc_pkg::MAP_DEPTH - 1)) begin
                    n_clr = '0;
                    n_st  = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.item.kind)
                        slc_pkg::KIND_LOAD: begin
                            line_we = 1'b1;
                            line_wa = i_head.item.pixel_x;
                            line_wd = i_head.item.pixel_color;
                        end
                        slc_pkg::KIND_ROW: begin
                            n_k  = '0;
                            n_st = S_RD;
                        end
                        default: n_st = S_EOL;
                    endcase
                end
            end
            S_RD: begin
                if (r_k == total) begin
                    n_st = S_FLUSH;
                end else if (!opaque) begin
                    n_k = r_k + 6'd1;
                end else begin
                    rd_en = 1'b1;
                    n_st  = S_WR;
                end
            end
            S_WR: begin
                emit = on_line &&
                       (!r_row.behind_background || r_line_q == i_cfg.background_color);
                if (!(emit && r_pv && !out_free)) begin
                    if (mi_ok) begin
                        map_we = 1'b1;
                        if (r_map_q != 8'd0) begin
                            n_coll = r_coll | r_map_q | bitm;
                        end
                    end
                    if (emit) begin
                        line_we = 1'b1;
                        if (r_pv) begin
                            n_valid = 1'b1;  n_kind = 1'b0;  n_x = r_px;
                            n_color = r_pc;  n_last = 1'b0;  n_mask = 8'd0;
                            n_olatch = 8'd0;  n_irq = 1'b0;
                        end
                        n_pv = 1'b1;  n_px = lx;  n_pc = pcolor;
                    end
                    n_k  = r_k + 6'd1;
                    n_st = S_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pv) begin
                    n_st = S_IDLE;
                end else if (out_free) begin
                    n_valid = 1'b1;  n_kind = 1'b0;  n_x = r_px;
                    n_color = r_pc;  n_last = 1'b1;  n_mask = 8'd0;
                    n_olatch = 8'd0;  n_irq = 1'b0;
                    n_pv = 1'b0;
                    n_st = S_IDLE;
                end
            end
            S_EOL: begin
                if (out_free) begin
                    n_latch  = r_latch | r_coll;
                    n_valid  = 1'b1;  n_kind = 1'b1;  n_x = 9'd0;
                    n_color  = 4'd0;  n_last = 1'b1;  n_mask = r_coll;
                    n_olatch = r_latch | r_coll;  n_irq = (r_coll != 8'd0);
                    n_coll   = 8'd0;
                    n_st     = S_CLEAR;
                end
            end
            default: n_st = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLEAR;
            r_clr   <= '0;
            r_k     <= '0;
            r_coll  <= 8'd0;
            r_latch <= 8'd0;
            r_pv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_clr   <= n_clr;
            r_k     <= n_k;
            r_coll  <= n_coll;
            r_latch <= n_latch;
            r_pv    <= n_pv;
            o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px              <= n_px;
        r_pc              <= n_pc;
        o_result_kind     <= n_kind;
        o_out_x           <= n_x;
        o_out_color       <= n_color;
        o_last            <= n_last;
        o_collided_mask   <= n_mask;
        o_collision_latch <= n_olatch;
        o_collision_irq   <= n_irq;
        if (o_pop) begin
            r_row <= i_head.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line[line_wa] <= line_wd;
        end
        if (rd_en) begin
            r_line_q <= r_line[lx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_wa] <= map_wd;
        end
        if (rd_en && mi_ok) begin
            r_map_q <= r_map[mi];
        end
    end
endmodule
`default_nettype wire

/* design/sprite_line_compositor.sv */
// Top level: sprite line compositor with collision detection.
// Input channel (i_valid/o_ready): one word per request. A background load
// writes the line store, a sprite row draws up to 48 pixels, end of line
// returns one report word. Unused request codes are dropped, as are loads past the line.
// Output channel (o_valid/i_ready): pixel writes in line order per row, the
// last word of a row flagged by o_last; end of line gives a report with the
// collided mask, the updated latch and the interrupt bit.
// Timing: a front stage feeds a two-entry queue; after the pop cycle the back
// walks one sprite pixel position per cycle when transparent, and for an opaque
// one reads, then writes line store and collision map (the write waits while a
// stalled receiver blocks a new word). A row ends with an end check and the flush
// of its last word. A load writes the line store in its pop cycle.
// End of line pops and sends a report, then a pass clears all 560 entries of
// the collision map; the same pass runs after reset. Queued words wait.
// A stalled receiver holds one word in the output register and one pending
// word; the back then stops and the queue fills, dropping o_ready.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// once and belong to idle periods.
`default_nettype none
`include "sprite_line_compositor_defines.svh"
module sprite_line_compositor (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_index,
    input  wire [3:0]  i_cfg_data,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [1:0]  i_req_type,
    input  wire [8:0]  i_pixel_x,
    input  wire [3:0]  i_pixel_color,
    input  wire [2:0]  i_sprite_index,
    input  wire [8:0]  i_sprite_x,
    input  wire [23:0] i_row_bits,
    input  wire        i_multicolor,
    input  wire        i_expand_x,
    input  wire        i_behind_background,
    input  wire [3:0]  i_sprite_color,
    output logic       o_valid,
    input  wire        i_ready,
    output logic       o_result_kind,
    output logic [8:0] o_out_x,
    output logic [3:0] o_out_color,
    output logic       o_last,
    output logic [7:0] o_collided_mask,
    output logic [7:0] o_collision_latch,
    output logic       o_collision_irq
);
    slc_pkg::t_cfg   r_cfg;
    slc_pkg::t_item  item;
    slc_pkg::t_qhead head;
    logic push, full, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.background_color <= 4'd6;
            r_cfg.multicolor_zero  <= 4'd0;
            r_cfg.multicolor_one   <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slc_pkg::CFG_BG:  r_cfg.background_color <= i_cfg_data;
                slc_pkg::CFG_MC0: r_cfg.multicolor_zero  <= i_cfg_data;
                slc_pkg::CFG_MC1: r_cfg.multicolor_one   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    slc_front u_front (
        .i_valid(i_valid), .o_ready(o_ready), .i_req_type(i_req_type),
        .i_pixel_x(i_pixel_x), .i_pixel_color(i_pixel_color),
        .i_sprite_index(i_sprite_index), .i_sprite_x(i_sprite_x),
        .i_row_bits(i_row_bits), .i_multicolor(i_multicolor),
        .i_expand_x(i_expand_x), .i_behind_background(i_behind_background),
        .i_sprite_color(i_sprite_color), .i_q_full(full),
        .o_push(push), .o_item(item)
    );

    slc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(item),
        .o_full(full), .i_pop(pop), .o_head(head)
    );

    slc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_head(head),
        .o_pop(pop), .o_valid(o_valid), .i_ready(i_ready),
        .o_result_kind(o_result_kind), .o_out_x(o_out_x),
        .o_out_color(o_out_color), .o_last(o_last),
        .o_collided_mask(o_collided_mask),
        .o_collision_latch(o_collision_latch),
        .o_collision_irq(o_collision_irq)
    );

    `SLC_ASSERT_NOW(a_report_last, i_clk, i_rst_n, o_valid && o_result_kind, o_last, "report without last")
    `SLC_ASSERT_NOW(a_irq_mask, i_clk, i_rst_n, o_valid && o_result_kind, o_collision_irq == (o_collided_mask != 8'd0), "irq disagrees with mask")
    `SLC_ASSERT_NOW(a_latch_cover, i_clk, i_rst_n, o_valid && o_result_kind, (o_collided_mask & ~o_collision_latch) == 8'd0, "latch misses mask bits")
    `SLC_ASSERT_NOW(a_write_zero, i_clk, i_rst_n, o_valid && !o_result_kind, (o_collided_mask == 8'd0) && !o_collision_irq, "pixel word carries report fields")
endmodule
`default_nettype wire
